FILE: sv/ffa_pkg.sv
`timescale 1ns / 1ps
// Package for the first-fit block allocator: status and operation codes and the
// command and status structs between the controller and the datapath. No dependencies.
package ffa_pkg;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_RUN    = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_ZERO_LEN  = 3'd4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic       load;
		logic       clear_step;
		logic       slot_step;
		logic       run_step;
		logic       commit;
		logic       hit_step;
		logic       fill_step;
		logic       respond;
		logic [2:0] code;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic op_free;
		logic len_zero;
		logic slot_found;
		logic slot_none;
		logic run_found;
		logic run_none;
		logic hit_found;
		logic hit_none;
		logic fill_last;
	} dp_stat_t;

endpackage

FILE: sv/first_fit_block_allocator_top.sv
`timescale 1ns / 1ps
// Allocate: the free-slot search and the block map scan (one block a cycle through the
// map RAM) set how long it takes at most. Free: the owner table scan sets it.
// Zero length: answered from the check state. One transaction at a time; done pulses
// one cycle per transaction. After reset the block map is cleared block by block with
// busy held high.
// Depends on ffa_pkg, ffa_ctrl, ffa_dp and ffa_ram.
module first_fit_block_allocator_top #(
	parameter int NUM_BLOCKS  = 64,
	parameter int MAX_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [15:0] owner_id,
	input  logic [6:0]  run_length,
	output logic        done,
	output logic [2:0]  status,
	output logic [5:0]  start_block
);

	ffa_pkg::dp_cmd_t  cmd;
	ffa_pkg::dp_stat_t st;

	ffa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.st    (st)
	);

	ffa_dp #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.operation  (operation),
		.owner_id   (owner_id),
		.run_length (run_length),
		.cmd        (cmd),
		.st         (st),
		.done       (done),
		.status     (status),
		.start_block(start_block)
	);

endmodule

FILE: sv/ffa_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/ffa_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the first-fit block allocator.
// Depends on ffa_pkg for the command and status structs and the status codes.
module ffa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output ffa_pkg::dp_cmd_t cmd,
	input  ffa_pkg::dp_stat_t st
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_CHECK  = 3'd2;
	localparam logic [2:0] S_SLOT   = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_COMMIT = 3'd5;
	localparam logic [2:0] S_HIT    = 3'd6;
	localparam logic [2:0] S_FILL   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.code = ffa_pkg::ST_OK;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (st.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.op_free) begin
					state_d = S_HIT;
				end else if (st.len_zero) begin
					cmd.respond = 1'b1;
					cmd.code    = ffa_pkg::ST_ZERO_LEN;
					state_d     = S_IDLE;
				end else begin
					state_d = S_SLOT;
				end
			end
			S_SLOT: begin
				cmd.slot_step = 1'b1;
				if (st.slot_found) begin
					state_d = S_SCAN;
				end else if (st.slot_none) begin
					cmd.respond = 1'b1;
					cmd.code    = ffa_pkg::ST_FULL;
					state_d     = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.run_step = 1'b1;
				if (st.run_found) begin
					state_d = S_COMMIT;
				end else if (st.run_none) begin
					cmd.respond = 1'b1;
					cmd.code    = ffa_pkg::ST_NO_RUN;
					state_d     = S_IDLE;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_FILL;
			end
			S_HIT: begin
				cmd.hit_step = 1'b1;
				if (st.hit_found) begin
					state_d = S_FILL;
				end else if (st.hit_none) begin
					cmd.respond = 1'b1;
					cmd.code    = ffa_pkg::ST_NOT_FOUND;
					state_d     = S_IDLE;
				end
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
				if (st.fill_last) begin
					cmd.respond = 1'b1;
					cmd.code    = ffa_pkg::ST_OK;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Every transaction ends in exactly one response and a return to idle.
	a_resp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.respond |=> state_q == S_IDLE)
		else $error("response not followed by idle");

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == S_CHECK)
		else $error("accepted transaction did not reach the check state");

	a_fill_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL && !st.fill_last |=> state_q == S_FILL)
		else $error("run update left before its last block");

	a_run_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(st.run_found && st.run_none) && !(st.hit_found && st.hit_none))
		else $error("search reported both a match and no match");

endmodule

FILE: sv/ffa_dp.sv
`timescale 1ns / 1ps
// Datapath of the first-fit block allocator: block map RAM, owner table RAM,
// valid bits, scan counters and result registers. Depends on ffa_pkg and ffa_ram.
module ffa_dp #(
	parameter int NUM_BLOCKS  = 64,
	parameter int MAX_ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              operation,
	input  logic [15:0]       owner_id,
	input  logic [6:0]        run_length,
	input  ffa_pkg::dp_cmd_t  cmd,
	output ffa_pkg::dp_stat_t st,
	output logic              done,
	output logic [2:0]        status,
	output logic [5:0]        start_block
);

	localparam int BW = $clog2(NUM_BLOCKS);
	localparam int EW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int LW = (CW > 7) ? CW + 1 : 8;
	localparam int SW = (BW > 7) ? BW + 1 : 8;
	localparam int TW = 16 + BW + 7;
	localparam logic [BW-1:0] BLAST = BW'(NUM_BLOCKS - 1);
	localparam logic [EW-1:0] ELAST = EW'(MAX_ENTRIES - 1);

	// Request fields.
	logic        op_q;
	logic [15:0] id_q;
	logic [6:0]  len_q;

	// Control registers.
	logic [BW-1:0]          blk_q;
	logic [EW-1:0]          ent_q;
	logic                   issue_q;
	logic                   blk_vld_s1;
	logic [BW-1:0]          blk_idx_s1;
	logic                   ent_vld_s1;
	logic [EW-1:0]          ent_idx_s1;
	logic [CW-1:0]          count_q;
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [EW-1:0]          slot_q;
	logic [BW-1:0]          fill_ptr_q;
	logic [6:0]             rem_q;
	logic [BW-1:0]          res_start_q;
	logic                   done_q;
	logic [2:0]             status_q;
	logic [5:0]             start_q;

	// RAM ports.
	logic          map_we;
	logic [BW-1:0] map_waddr;
	logic          map_wdata;
	logic          map_used;
	logic [TW-1:0] tab_rdata;
	logic [15:0]   tab_owner;
	logic [BW-1:0] tab_start;
	logic [6:0]    tab_len;

	logic [LW-1:0]  cnt_inc;
	logic [SW-1:0]  rs_wide;
	logic [BW-1:0]  run_start;
	logic           run_hit;
	logic           ent_hit;
	logic [BW+5:0]  res_ext;

	assign map_we    = cmd.clear_step || cmd.fill_step;
	assign map_waddr = cmd.clear_step ? blk_q : fill_ptr_q;
	assign map_wdata = cmd.fill_step && (op_q == ffa_pkg::OP_ALLOC);

	ffa_ram #(
		.WIDTH(1),
		.DEPTH(NUM_BLOCKS)
	) u_map (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(map_wdata),
		.raddr(blk_q),
		.rdata(map_used)
	);

	ffa_ram #(
		.WIDTH(TW),
		.DEPTH(MAX_ENTRIES)
	) u_tab (
		.clk  (clk),
		.we   (cmd.commit),
		.waddr(slot_q),
		.wdata({id_q, res_start_q, len_q}),
		.raddr(ent_q),
		.rdata(tab_rdata)
	);

	assign tab_owner = tab_rdata[TW-1 -: 16];
	assign tab_start = tab_rdata[BW+6:7];
	assign tab_len   = tab_rdata[6:0];

	// A run ends on this block when the free count reaches the requested length.
	assign cnt_inc   = LW'(count_q) + LW'(1);
	assign run_hit   = blk_vld_s1 && !map_used && (cnt_inc == LW'(len_q));
	assign rs_wide   = SW'(blk_idx_s1) - SW'(len_q) + SW'(1);
	assign run_start = rs_wide[BW-1:0];
	assign ent_hit   = ent_vld_s1 && valid_q[ent_idx_s1] && (tab_owner == id_q);

	always_comb begin
		st            = '0;
		st.clear_last = cmd.clear_step && (blk_q == BLAST);
		st.op_free    = (op_q == ffa_pkg::OP_FREE);
		st.len_zero   = (len_q == 7'd0);
		st.slot_found = cmd.slot_step && !valid_q[ent_q];
		st.slot_none  = cmd.slot_step && valid_q[ent_q] && (ent_q == ELAST);
		st.run_found  = cmd.run_step && run_hit;
		st.run_none   = cmd.run_step && !run_hit && blk_vld_s1 && (blk_idx_s1 == BLAST);
		st.hit_found  = cmd.hit_step && ent_hit;
		st.hit_none   = cmd.hit_step && !ent_hit && ent_vld_s1 && (ent_idx_s1 == ELAST);
		st.fill_last  = cmd.fill_step && (rem_q == 7'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q      <= '0;
			ent_q      <= '0;
			issue_q    <= 1'b0;
			blk_vld_s1 <= 1'b0;
			blk_idx_s1 <= '0;
			ent_vld_s1 <= 1'b0;
			ent_idx_s1 <= '0;
			count_q    <= '0;
			valid_q    <= '0;
			slot_q     <= '0;
			fill_ptr_q <= '0;
			rem_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			blk_vld_s1 <= cmd.run_step && issue_q;
			blk_idx_s1 <= blk_q;
			ent_vld_s1 <= cmd.hit_step && issue_q;
			ent_idx_s1 <= ent_q;
			done_q     <= cmd.respond;

			if (cmd.load) begin
				blk_q   <= '0;
				ent_q   <= '0;
				issue_q <= 1'b1;
				count_q <= '0;
			end
			if (cmd.clear_step) begin
				blk_q <= blk_q + BW'(1);
			end
			if (cmd.slot_step) begin
				ent_q <= ent_q + EW'(1);
				if (!valid_q[ent_q]) begin
					slot_q <= ent_q;
				end
			end
			if (cmd.run_step) begin
				if (issue_q) begin
					if (blk_q == BLAST) begin
						issue_q <= 1'b0;
					end else begin
						blk_q <= blk_q + BW'(1);
					end
				end
				if (blk_vld_s1) begin
					count_q <= map_used ? '0 : cnt_inc[CW-1:0];
				end
				if (run_hit) begin
					fill_ptr_q <= run_start;
					rem_q      <= len_q;
				end
			end
			if (cmd.hit_step) begin
				if (issue_q) begin
					if (ent_q == ELAST) begin
						issue_q <= 1'b0;
					end else begin
						ent_q <= ent_q + EW'(1);
					end
				end
				if (ent_hit) begin
					fill_ptr_q          <= tab_start;
					rem_q               <= tab_len;
					valid_q[ent_idx_s1] <= 1'b0;
				end
			end
			if (cmd.commit) begin
				valid_q[slot_q] <= 1'b1;
			end
			if (cmd.fill_step) begin
				fill_ptr_q <= fill_ptr_q + BW'(1);
				rem_q      <= rem_q - 7'd1;
			end
		end
	end

	assign res_ext = {6'd0, res_start_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			id_q  <= owner_id;
			len_q <= run_length;
		end
		if (cmd.run_step && run_hit) begin
			res_start_q <= run_start;
		end else if (cmd.hit_step && ent_hit) begin
			res_start_q <= tab_start;
		end
		if (cmd.respond) begin
			status_q <= cmd.code;
			start_q  <= (cmd.code == ffa_pkg::ST_OK) ? res_ext[5:0] : 6'd0;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign start_block = start_q;

	a_resp_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.respond |=> done_q && status_q == $past(cmd.code))
		else $error("response not presented on the result ports");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q != ffa_pkg::ST_OK |-> start_q == 6'd0)
		else $error("error result carries a nonzero start block");

	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !valid_q[slot_q])
		else $error("allocation overwrites a live table entry");

	a_fill_map: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_step && op_q == ffa_pkg::OP_ALLOC |-> rem_q != 7'd0)
		else $error("run update past the end of the run");

endmodule

FILE: bench/first_fit_block_allocator_checker.sv
`timescale 1ns / 1ps
// Checker for the first-fit block allocator: tracks the block map and owner table,
// predicts the status and start block of each transaction and compares the results.
// Depends on ffa_pkg.
module first_fit_block_allocator_checker #(
	parameter int NUM_BLOCKS  = 64,
	parameter int MAX_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        operation,
	input  logic [15:0] owner_id,
	input  logic [6:0]  run_length,
	input  logic        done,
	input  logic [2:0]  status,
	input  logic [5:0]  start_block,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] start_block;
	} outcome_t;

	logic [NUM_BLOCKS-1:0]  block_map;
	logic [MAX_ENTRIES-1:0] slot_live;
	logic [15:0]            slot_owner [MAX_ENTRIES];
	int                     slot_first [MAX_ENTRIES];
	int                     slot_len   [MAX_ENTRIES];
	outcome_t               outcome_q[$];

	// Updates the map and table for one request and returns its outcome.
	function automatic outcome_t apply_request(input logic op, input logic [15:0] id,
			input logic [6:0] len);
		outcome_t res;
		int free_slot;
		int hit;
		int run;
		int first;
		res.status = ffa_pkg::ST_OK;
		res.start_block = '0;
		free_slot = -1;
		hit = -1;
		run = 0;
		first = -1;
		if (op == ffa_pkg::OP_ALLOC) begin
			for (int i = 0; i < MAX_ENTRIES; i++)
				if (!slot_live[i] && free_slot < 0)
					free_slot = i;
			if (len == 0) begin
				res.status = ffa_pkg::ST_ZERO_LEN;
			end else if (free_slot < 0) begin
				res.status = ffa_pkg::ST_FULL;
			end else begin
				for (int b = 0; b < NUM_BLOCKS; b++) begin
					if (block_map[b]) begin
						run = 0;
					end else begin
						run++;
						if (run == int'(len) && first < 0)
							first = b + 1 - int'(len);
					end
				end
				if (first < 0) begin
					res.status = ffa_pkg::ST_NO_RUN;
				end else begin
					for (int b = 0; b < NUM_BLOCKS; b++)
						if (b >= first && b < first + int'(len))
							block_map[b] = 1'b1;
					slot_live[free_slot] = 1'b1;
					slot_owner[free_slot] = id;
					slot_first[free_slot] = first;
					slot_len[free_slot] = int'(len);
					res.start_block = 6'(first);
				end
			end
		end else begin
			for (int i = 0; i < MAX_ENTRIES; i++)
				if (slot_live[i] && slot_owner[i] == id && hit < 0)
					hit = i;
			if (hit < 0) begin
				res.status = ffa_pkg::ST_NOT_FOUND;
			end else begin
				for (int b = 0; b < NUM_BLOCKS; b++)
					if (b >= slot_first[hit] && b < slot_first[hit] + slot_len[hit])
						block_map[b] = 1'b0;
				slot_live[hit] = 1'b0;
				res.start_block = 6'(slot_first[hit]);
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			block_map = '0;
			slot_live = '0;
			outcome_q.delete();
			outstanding = 0;
		end else begin
			if (start && !busy)
				outcome_q.push_back(apply_request(operation, owner_id, run_length));
			if (done) begin
				got.status = status;
				got.start_block = start_block;
				if (outcome_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with no transaction pending: status %0d start %0d",
							$realtime, got.status, got.start_block);
				end else begin
					want = outcome_q.pop_front();
					if (want.status !== got.status || want.start_block !== got.start_block) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch: expected status %0d start %0d, %s %0d %s %0d",
								$realtime, want.status, want.start_block, "got status",
								got.status, "start", got.start_block);
					end
				end
			end
			outstanding = outcome_q.size();
		end
	end

endmodule

FILE: bench/tb_first_fit_block_allocator_top.sv
`timescale 1ns / 1ps
// Testbench top for the first-fit block allocator: drives directed and random allocate
// and free transactions with random idle bursts and gives the verdict.
// Depends on ffa_pkg, first_fit_block_allocator_top and first_fit_block_allocator_checker.
module tb_first_fit_block_allocator_top;

	localparam int NUM_BLOCKS      = 64;
	localparam int MAX_ENTRIES     = 16;
	localparam int RANDOM_REQUESTS = 450;
	localparam int CALM_TAIL       = 60;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int DRAIN_CYCLES    = 200;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        start      = 1'b0;
	logic        operation  = ffa_pkg::OP_ALLOC;
	logic [15:0] owner_id   = '0;
	logic [6:0]  run_length = '0;
	logic        busy;
	logic        done;
	logic [2:0]  status;
	logic [5:0]  start_block;
	int          mismatches;
	int          outstanding;
	int          stall_cycles = 0;
	logic [15:0] issued_ids[$];
	logic        gappy;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	first_fit_block_allocator_top #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.MAX_ENTRIES(MAX_ENTRIES)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.owner_id   (owner_id),
		.run_length (run_length),
		.done       (done),
		.status     (status),
		.start_block(start_block)
	);

	first_fit_block_allocator_checker #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.MAX_ENTRIES(MAX_ENTRIES)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.owner_id   (owner_id),
		.run_length (run_length),
		.done       (done),
		.status     (status),
		.start_block(start_block),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// Holds start high until the transaction is taken; the caller lowers it if it idles.
	task automatic send_request(input logic op, input logic [15:0] id, input logic [6:0] len);
		@(negedge clk);
		start <= 1'b1;
		operation <= op;
		owner_id <= id;
		run_length <= len;
		do @(posedge clk); while (busy);
	endtask

	task automatic hold_off(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
			operation <= 1'($urandom);
			owner_id <= 16'($urandom);
			run_length <= 7'($urandom);
		end
	endtask

	// Allocations mostly use a small pool of owner ids so that duplicates occur, and
	// frees mostly name an id that was handed out earlier.
	task automatic random_request();
		logic [15:0] id;
		logic [6:0] len;
		int pick;
		int idx;
		pick = $urandom_range(99);
		if (pick < 55 || issued_ids.size() == 0) begin
			id = ($urandom_range(99) < 65) ? 16'h0100 + 16'($urandom_range(15)) : 16'($urandom);
			pick = $urandom_range(99);
			if (pick < 3)
				len = 7'd0;
			else if (pick < 6)
				len = 7'($urandom_range(65, 127));
			else if (pick < 16)
				len = 7'($urandom_range(17, 64));
			else
				len = 7'($urandom_range(1, 16));
			if (len != 0 && issued_ids.size() < 48)
				issued_ids.push_back(id);
			send_request(ffa_pkg::OP_ALLOC, id, len);
		end else begin
			if ($urandom_range(9) < 8) begin
				idx = $urandom_range(issued_ids.size() - 1);
				id = issued_ids[idx];
				issued_ids.delete(idx);
			end else begin
				id = 16'($urandom);
			end
			send_request(ffa_pkg::OP_FREE, id, 7'($urandom));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_request(ffa_pkg::OP_ALLOC, 16'h1234, 7'd0);
		send_request(ffa_pkg::OP_FREE, 16'hFFFF, 7'h7F);
		send_request(ffa_pkg::OP_ALLOC, 16'h0000, 7'd64);
		send_request(ffa_pkg::OP_ALLOC, 16'h0001, 7'd1);
		send_request(ffa_pkg::OP_FREE, 16'h0000, 7'd0);
		send_request(ffa_pkg::OP_ALLOC, 16'hFFFF, 7'd127);
		// Sixteen runs of four fill both the table and the map; the last run ends on
		// the last block. Ids repeat so that the first and last slot share one.
		for (int k = 0; k < MAX_ENTRIES; k++)
			send_request(ffa_pkg::OP_ALLOC, 16'h0100 + 16'(k % 15), 7'd4);
		send_request(ffa_pkg::OP_ALLOC, 16'h5555, 7'd1);
		send_request(ffa_pkg::OP_ALLOC, 16'h5555, 7'd0);
		send_request(ffa_pkg::OP_FREE, 16'h0100, 7'd0);
		send_request(ffa_pkg::OP_FREE, 16'h0100, 7'd0);
		for (int k = 1; k < MAX_ENTRIES - 1; k++)
			issued_ids.push_back(16'h0100 + 16'(k));

		gappy = 1'b1;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 40 == 0)
				gappy = ($urandom_range(3) != 0);
			if (n == RANDOM_REQUESTS / 2) begin
				hold_off(1);
				while (outstanding != 0)
					@(negedge clk);
			end
			if (gappy && n < RANDOM_REQUESTS - CALM_TAIL && $urandom_range(2) == 0)
				hold_off($urandom_range(1, 16));
			random_request();
		end

		hold_off(1);
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_first_fit_block_allocator_top passed");
		else
			$display("tb_first_fit_block_allocator_top failed");
		$finish;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("tb_first_fit_block_allocator_top failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule

FILE: files.f
sv/ffa_pkg.sv
sv/ffa_ram.sv
sv/ffa_ctrl.sv
sv/ffa_dp.sv
sv/first_fit_block_allocator_top.sv
bench/first_fit_block_allocator_checker.sv
bench/tb_first_fit_block_allocator_top.sv
